### hw/rtl/srk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srk_pkg;

  localparam int Q_W = 17;
  localparam int OFF_W = 18;
  localparam int CURVE_W = 16;

  localparam logic [Q_W-1:0] Q16_ONE = 17'd65536;
  localparam logic [17:0] SAT_CAP = 18'd131072;
  localparam logic [CURVE_W-1:0] CURVE_MIN = 16'd1638;
  localparam logic [CURVE_W-1:0] CURVE_MAX = 16'd40960;

  // mode register bit positions
  localparam int MODE_DISPLAY = 0;
  localparam int MODE_INVERT = 1;

  typedef enum logic [1:0] {
    KS_ZERO = 2'd0,
    KS_ONE  = 2'd1,
    KS_POW  = 2'd2
  } key_sel_e;

  typedef enum logic [2:0] {
    CFG_HIGH_LIMIT  = 3'd0,
    CFG_HIGH_FADE   = 3'd1,
    CFG_LOW_FADE    = 3'd2,
    CFG_LOW_LIMIT   = 3'd3,
    CFG_FADE_CURVES = 3'd4,
    CFG_SAT_OFFSET  = 3'd5,
    CFG_MIX_AMOUNT  = 3'd6,
    CFG_MODE        = 3'd7
  } cfg_reg_e;

  function automatic logic [Q_W-1:0] cap_one(input logic [Q_W-1:0] v);
    return (v > Q16_ONE) ? Q16_ONE : v;
  endfunction

  function automatic logic [CURVE_W-1:0] clamp_curve(input logic [CURVE_W-1:0] v);
    logic [CURVE_W-1:0] r;
    r = v;
    if (r < CURVE_MIN) r = CURVE_MIN;
    if (r > CURVE_MAX) r = CURVE_MAX;
    return r;
  endfunction

  // floor square root, elaboration use only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] vv;
    r = 64'd0;
    b = 64'd1 << 62;
    vv = v;
    for (int i = 0; i < 32; i++) begin
      if (vv >= r + b) begin
        vv = vv - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q0.30 factor 2^-(2^-(k+1))
  function automatic logic [29:0] exp_fac(input int k);
    logic [63:0] t;
    t = isqrt64(64'd1 << 59);
    for (int i = 0; i < k; i++) begin
      t = isqrt64(t << 30);
    end
    return t[29:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/saturation_range_keyer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Saturation range keyer, one RGBA pixel per beat.
// Input channel: in_valid_i / in_stall_o with red_i, green_i, blue_i, alpha_in_i.
// Output channel: out_valid_o / out_stall_i with out_red_o .. out_alpha_o.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (high_limit, high_fade,
// low_fade, low_limit, fade_curves, sat_offset, mix_amount, mode); write only
// while no pixel is in flight.
// Throughput is one pixel per clock while the spare output register is empty; the
// depth comes from the saturation divider (18 stages), two roll-off units in
// parallel (16-bit ratio divider, 16 squaring stages, 23-bit exponent divider,
// 16 product stages) and the key multiply/mix stages.
// Reset clears every valid bit and loads the register defaults.
// When the receiver stalls, a second output register catches the beat still in
// flight; while it is full the pipeline holds and in_stall_o is high. Nothing is
// dropped or repeated.
module saturation_range_keyer_core #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  input  logic [CHANNEL_BITS-1:0] alpha_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CHANNEL_BITS-1:0] out_red_o,
  output logic [CHANNEL_BITS-1:0] out_green_o,
  output logic [CHANNEL_BITS-1:0] out_blue_o,
  output logic [CHANNEL_BITS-1:0] out_alpha_o,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_idx_i,
  input  logic [31:0]             cfg_data_i
);
  import srk_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int PW = 4 * CB;

  // config registers
  logic [Q_W-1:0]   high_limit_q, high_fade_q, low_fade_q, low_limit_q, mix_amount_q;
  logic [31:0]      fade_curves_q;
  logic [OFF_W-1:0] sat_offset_q;
  logic [1:0]       mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_limit_q  <= Q16_ONE;
      high_fade_q   <= Q16_ONE;
      low_fade_q    <= '0;
      low_limit_q   <= '0;
      fade_curves_q <= 32'h2000_2000;
      sat_offset_q  <= '0;
      mix_amount_q  <= '0;
      mode_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_HIGH_LIMIT:  high_limit_q  <= cfg_data_i[Q_W-1:0];
        CFG_HIGH_FADE:   high_fade_q   <= cfg_data_i[Q_W-1:0];
        CFG_LOW_FADE:    low_fade_q    <= cfg_data_i[Q_W-1:0];
        CFG_LOW_LIMIT:   low_limit_q   <= cfg_data_i[Q_W-1:0];
        CFG_FADE_CURVES: fade_curves_q <= cfg_data_i;
        CFG_SAT_OFFSET:  sat_offset_q  <= cfg_data_i[OFF_W-1:0];
        CFG_MIX_AMOUNT:  mix_amount_q  <= cfg_data_i[Q_W-1:0];
        CFG_MODE:        mode_q        <= cfg_data_i[1:0];
      endcase
    end
  end

  logic [Q_W-1:0]     hr, hw, la, lb, mz;
  logic [CURVE_W-1:0] hcurve, lcurve;

  assign hr     = cap_one(high_limit_q);
  assign hw     = Q16_ONE - cap_one(high_fade_q);
  assign la     = cap_one(low_limit_q);
  assign lb     = cap_one(low_fade_q);
  assign mz     = cap_one(mix_amount_q);
  assign hcurve = clamp_curve(fade_curves_q[15:0]);
  assign lcurve = clamp_curve(fade_curves_q[31:16]);

  // pipeline advances unless the spare output register is holding a beat
  logic skid_v_q;
  logic en;
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // saturation
  logic           sv;
  logic [Q_W-1:0] sat;
  logic [PW-1:0]  spix;

  srk_sat #(
    .CB (CB)
  ) u_sat (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .alpha_i      (alpha_in_i),
    .sat_offset_i (sat_offset_q),
    .valid_o      (sv),
    .sat_o        (sat),
    .pix_o        (spix)
  );

  // key branch selection
  logic signed [18:0] sat_s, hr_s, hw_s, la_s, lb_s;
  key_sel_e           hi_sel_d, lo_sel_d;

  assign sat_s = $signed({2'b00, sat});
  assign hr_s  = $signed({2'b00, hr});
  assign hw_s  = $signed({2'b00, hw});
  assign la_s  = $signed({2'b00, la});
  assign lb_s  = $signed({2'b00, lb});

  always_comb begin
    priority if (hr == '0)             hi_sel_d = KS_ZERO;
    else if (hr_s - hw_s >= sat_s)     hi_sel_d = KS_ONE;
    else if (hr_s >= sat_s)            hi_sel_d = KS_POW;
    else                               hi_sel_d = KS_ZERO;
  end

  always_comb begin
    priority if (la == Q16_ONE)        lo_sel_d = KS_ZERO;
    else if (la_s + lb_s <= sat_s)     lo_sel_d = KS_ONE;
    else if (la_s <= sat_s)            lo_sel_d = KS_POW;
    else                               lo_sel_d = KS_ZERO;
  end

  logic           pv_q;
  key_sel_e       hi_sel_q, lo_sel_q;
  logic [Q_W-1:0] hi_num_q, lo_num_q;
  logic [PW-1:0]  ppix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= sv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hi_sel_q <= hi_sel_d;
      lo_sel_q <= lo_sel_d;
      hi_num_q <= hr - sat;
      lo_num_q <= sat - la;
      ppix_q   <= spix;
    end
  end

  // roll-off curves
  logic              hv, lv;
  logic [Q_W-1:0]    hpw, lpw;
  logic [PW+1:0]     htag;
  logic [1:0]        ltag;

  srk_pow #(
    .TW (PW + 2)
  ) u_hi_pow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pv_q),
    .num_i   (hi_num_q),
    .den_i   (hw),
    .curve_i (hcurve),
    .tag_i   ({hi_sel_q, ppix_q}),
    .valid_o (hv),
    .pw_o    (hpw),
    .tag_o   (htag)
  );

  srk_pow #(
    .TW (2)
  ) u_lo_pow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pv_q),
    .num_i   (lo_num_q),
    .den_i   (lb),
    .curve_i (lcurve),
    .tag_i   (lo_sel_q),
    .valid_o (lv),
    .pw_o    (lpw),
    .tag_o   (ltag)
  );

  function automatic logic [Q_W-1:0] pick(input key_sel_e sel, input logic [Q_W-1:0] pw);
    logic [Q_W-1:0] r;
    unique case (sel)
      KS_ONE:  r = Q16_ONE;
      KS_POW:  r = pw;
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [Q_W-1:0]   hi_val, lo_val;
  logic [2*Q_W-1:0] kprod;
  assign hi_val = pick(key_sel_e'(htag[PW+1:PW]), hpw);
  assign lo_val = pick(key_sel_e'(ltag), lpw);
  assign kprod  = hi_val * lo_val;

  logic           av_q;
  logic [Q_W-1:0] key_q;
  logic [PW-1:0]  apix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q <= 1'b0;
    end else if (en) begin
      av_q <= hv & lv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      key_q  <= kprod[2*Q_W-2:16];
      apix_q <= htag[PW-1:0];
    end
  end

  // mix toward one
  logic [2*Q_W-1:0] mprod;
  assign mprod = (Q16_ONE - key_q) * mz;

  logic           bv_q;
  logic [Q_W-1:0] bkey_q, bmix_q;
  logic [PW-1:0]  bpix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= 1'b0;
    end else if (en) begin
      bv_q <= av_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bkey_q <= key_q;
      bmix_q <= mprod[2*Q_W-2:16];
      bpix_q <= apix_q;
    end
  end

  logic [Q_W-1:0] mixed, fkey;
  logic [CB-1:0]  ck;
  logic [PW-1:0]  fin;

  assign mixed = bkey_q + bmix_q;
  assign fkey  = mode_q[MODE_INVERT] ? (Q16_ONE - mixed) : mixed;

  if (CB >= 20) begin : g_key_up
    assign ck = CB'(fkey) << (CB - 20);
  end else begin : g_key_dn
    assign ck = CB'(fkey >> (20 - CB));
  end

  assign fin = mode_q[MODE_DISPLAY] ? {ck, ck, ck, bpix_q[CB-1:0]}
                                    : {bpix_q[PW-1:CB], ck};

  // output register plus spare
  logic          out_v_q, out_v_d, skid_v_d;
  logic          load_out, load_skid, move_skid;
  logic [PW-1:0] out_q, skid_q;

  always_comb begin
    load_out  = 1'b0;
    load_skid = 1'b0;
    move_skid = 1'b0;
    out_v_d   = out_v_q;
    skid_v_d  = skid_v_q;
    if (skid_v_q) begin
      if (!out_stall_i) begin
        move_skid = 1'b1;
        skid_v_d  = 1'b0;
      end
    end else if (bv_q) begin
      if (!out_v_q || !out_stall_i) begin
        load_out = 1'b1;
        out_v_d  = 1'b1;
      end else begin
        load_skid = 1'b1;
        skid_v_d  = 1'b1;
      end
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_skid) begin
      out_q <= skid_q;
    end else if (load_out) begin
      out_q <= fin;
    end
    if (load_skid) begin
      skid_q <= fin;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_red_o   = out_q[4*CB-1:3*CB];
  assign out_green_o = out_q[3*CB-1:2*CB];
  assign out_blue_o  = out_q[2*CB-1:CB];
  assign out_alpha_o = out_q[CB-1:0];

endmodule

`default_nettype wire

### hw/rtl/srk_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage. num_hi_i must be below den_i.
module srk_div #(
  parameter int QW = 16,
  parameter int DW = 17,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] num_hi_i,
  input  logic [QW-1:0] num_lo_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic [DW-1:0] rem_s [QW];
  logic [QW-1:0] lo_s  [QW+1];
  logic [DW-1:0] den_s [QW+1];
  logic [TW-1:0] tag_s [QW+1];
  logic          v_s   [QW+1];

  assign rem_s[0] = num_hi_i;
  assign lo_s[0]  = num_lo_i;
  assign den_s[0] = den_i;
  assign tag_s[0] = tag_i;
  assign v_s[0]   = valid_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [QW-1:0] lo_d;
    logic [QW-1:0] lo_q;
    logic [DW-1:0] den_q;
    logic [TW-1:0] tag_q;
    logic          v_q;

    assign trial = {rem_s[k], lo_s[k][QW-1]};
    assign diff  = trial - {1'b0, den_s[k]};
    assign ge    = trial >= {1'b0, den_s[k]};
    assign lo_d  = {lo_s[k][QW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q  <= lo_d;
        den_q <= den_s[k];
        tag_q <= tag_s[k];
      end
    end

    if (k < QW - 1) begin : g_rem
      logic [DW-1:0] rem_d;
      logic [DW-1:0] rem_q;
      assign rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q <= rem_d;
        end
      end
      assign rem_s[k+1] = rem_q;
    end

    assign lo_s[k+1]  = lo_q;
    assign den_s[k+1] = den_q;
    assign tag_s[k+1] = tag_q;
    assign v_s[k+1]   = v_q;
  end

  assign valid_o = v_s[QW];
  assign quo_o   = lo_s[QW];
  assign tag_o   = tag_s[QW];

endmodule

`default_nettype wire

### hw/rtl/srk_sat.sv
`timescale 1ns / 1ps
`default_nettype none

// Saturation (max-min)/(2-(max+min)), offset and clamp to [0,1].
module srk_sat #(
  parameter int CB = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [CB-1:0]              red_i,
  input  logic [CB-1:0]              green_i,
  input  logic [CB-1:0]              blue_i,
  input  logic [CB-1:0]              alpha_i,
  input  logic [srk_pkg::OFF_W-1:0]  sat_offset_i,
  output logic                       valid_o,
  output logic [srk_pkg::Q_W-1:0]    sat_o,
  output logic [4*CB-1:0]            pix_o
);
  import srk_pkg::*;

  localparam int DW = CB + 1;
  localparam int TW = 4 * CB + 3;
  localparam logic [CB+1:0] TWO_ONE = (CB+2)'(1) << (CB - 3);

  logic [CB-1:0]        mx, mn;
  logic [CB:0]          sum;
  logic signed [CB+1:0] d, dn;
  logic [DW-1:0]        ad;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
  end

  assign sum = {1'b0, mx} + {1'b0, mn};
  assign d   = $signed(TWO_ONE) - $signed({1'b0, sum});
  assign dn  = -d;
  assign ad  = d[CB+1] ? dn[CB:0] : d[CB:0];

  logic          s1_v_q;
  logic [CB-1:0] c_q;
  logic [DW-1:0] ad_q;
  logic          neg_q;
  logic [4*CB-1:0] pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q   <= mx - mn;
      ad_q  <= ad;
      neg_q <= d[CB+1];
      pix_q <= {red_i, green_i, blue_i, alpha_i};
    end
  end

  // quotient needs more than 18 bits (or divisor is zero) when c/4 >= |d|
  logic [DW-1:0] c_hi;
  logic          ovf;
  logic [TW-1:0] dtag_in, dtag_out;
  logic          dv;
  logic [17:0]   quo;

  assign c_hi    = DW'(c_q >> 2);
  assign ovf     = c_hi >= ad_q;
  assign dtag_in = {(c_q == '0), neg_q, ovf, pix_q};

  srk_div #(
    .QW (18),
    .DW (DW),
    .TW (TW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en_i),
    .valid_i  (s1_v_q),
    .num_hi_i (c_hi),
    .num_lo_i ({c_q[1:0], 16'd0}),
    .den_i    (ad_q),
    .tag_i    (dtag_in),
    .valid_o  (dv),
    .quo_o    (quo),
    .tag_o    (dtag_out)
  );

  logic               t_czero, t_neg, t_ovf;
  logic [17:0]        qm;
  logic signed [19:0] sgn, off, tot;
  logic [Q_W-1:0]     sat_d;

  assign t_czero = dtag_out[4*CB+2];
  assign t_neg   = dtag_out[4*CB+1];
  assign t_ovf   = dtag_out[4*CB];
  assign qm      = (t_ovf || quo > SAT_CAP) ? SAT_CAP : quo;
  assign sgn     = t_neg ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
  assign off     = $signed({{2{sat_offset_i[OFF_W-1]}}, sat_offset_i});
  assign tot     = sgn + off;

  always_comb begin
    if (t_czero || tot < 0) begin
      sat_d = '0;
    end else if (tot > $signed({3'b000, Q16_ONE})) begin
      sat_d = Q16_ONE;
    end else begin
      sat_d = tot[Q_W-1:0];
    end
  end

  logic            v_q;
  logic [Q_W-1:0]  sat_q;
  logic [4*CB-1:0] po_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q <= sat_d;
      po_q  <= dtag_out[4*CB-1:0];
    end
  end

  assign valid_o = v_q;
  assign sat_o   = sat_q;
  assign pix_o   = po_q;

endmodule

`default_nettype wire

### hw/rtl/srk_pow.sv
`timescale 1ns / 1ps
`default_nettype none

// Soft roll-off: x = num/den, then x^(8192/curve) via log2 squaring and 2^-y product.
module srk_pow #(
  parameter int TW = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [srk_pkg::Q_W-1:0]       num_i,
  input  logic [srk_pkg::Q_W-1:0]       den_i,
  input  logic [srk_pkg::CURVE_W-1:0]   curve_i,
  input  logic [TW-1:0]                 tag_i,
  output logic                          valid_o,
  output logic [srk_pkg::Q_W-1:0]       pw_o,
  output logic [TW-1:0]                 tag_o
);
  import srk_pkg::*;

  // ratio
  logic          xv;
  logic [15:0]   x;
  logic [TW-1:0] xtag;

  srk_div #(
    .QW (16),
    .DW (Q_W),
    .TW (TW)
  ) u_xdiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en_i),
    .valid_i  (valid_i),
    .num_hi_i (num_i),
    .num_lo_i (16'd0),
    .den_i    (den_i),
    .tag_i    (tag_i),
    .valid_o  (xv),
    .quo_o    (x),
    .tag_o    (xtag)
  );

  // normalize x to Q1.30
  logic [3:0] msb;
  always_comb begin
    msb = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) msb = 4'(i);
    end
  end

  logic          nv_q;
  logic [30:0]   m_q;
  logic [4:0]    e_q;
  logic          z_q;
  logic [TW-1:0] ntag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else if (en_i) begin
      nv_q <= xv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= 31'(x) << (5'd30 - {1'b0, msb});
      e_q    <= 5'd16 - {1'b0, msb};
      z_q    <= (x == 16'd0);
      ntag_q <= xtag;
    end
  end

  // log2 fraction bits, one squaring per stage
  logic [30:0]   sm_s [17];
  logic [15:0]   sf_s [17];
  logic [4:0]    se_s [17];
  logic          sz_s [17];
  logic [TW-1:0] st_s [17];
  logic          sv_s [17];

  assign sm_s[0] = m_q;
  assign sf_s[0] = 16'd0;
  assign se_s[0] = e_q;
  assign sz_s[0] = z_q;
  assign st_s[0] = ntag_q;
  assign sv_s[0] = nv_q;

  for (genvar k = 0; k < 16; k++) begin : g_sq
    logic [61:0]   prod;
    logic [31:0]   t;
    logic [30:0]   m_q2;
    logic [15:0]   f_q;
    logic [4:0]    e_q2;
    logic          z_q2;
    logic [TW-1:0] tag_q;
    logic          v_q;

    assign prod = sm_s[k] * sm_s[k];
    assign t    = prod[61:30];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= sv_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q2  <= t[31] ? t[31:1] : t[30:0];
        f_q   <= {sf_s[k][14:0], t[31]};
        e_q2  <= se_s[k];
        z_q2  <= sz_s[k];
        tag_q <= st_s[k];
      end
    end

    assign sm_s[k+1] = m_q2;
    assign sf_s[k+1] = f_q;
    assign se_s[k+1] = e_q2;
    assign sz_s[k+1] = z_q2;
    assign st_s[k+1] = tag_q;
    assign sv_s[k+1] = v_q;
  end

  // y = |log2 x| * 8192 / curve
  logic [20:0]   lg;
  logic          yv;
  logic [22:0]   ny;
  logic [TW:0]   ytag;

  assign lg = {sf_s[16] == 16'd0 ? se_s[16] : se_s[16], 16'd0} - {5'd0, sf_s[16]};

  srk_div #(
    .QW (23),
    .DW (CURVE_W),
    .TW (TW + 1)
  ) u_ydiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en_i),
    .valid_i  (sv_s[16]),
    .num_hi_i (CURVE_W'(lg[20:10])),
    .num_lo_i ({lg[9:0], 13'd0}),
    .den_i    (curve_i),
    .tag_i    ({sz_s[16], st_s[16]}),
    .valid_o  (yv),
    .quo_o    (ny),
    .tag_o    (ytag)
  );

  // 2^-frac as product of constant factors
  logic [30:0]   er_s [17];
  logic [15:0]   ef_s [16];
  logic [6:0]    eq_s [17];
  logic          ez_s [17];
  logic [TW-1:0] et_s [17];
  logic          ev_s [17];

  assign er_s[0] = 31'h4000_0000;
  assign ef_s[0] = ny[15:0];
  assign eq_s[0] = ny[22:16];
  assign ez_s[0] = ytag[TW];
  assign et_s[0] = ytag[TW-1:0];
  assign ev_s[0] = yv;

  for (genvar k = 0; k < 16; k++) begin : g_exp
    localparam logic [29:0] TK = exp_fac(k);
    logic [60:0]   prod;
    logic [30:0]   r_q;
    logic [6:0]    q_q;
    logic          z_q2;
    logic [TW-1:0] tag_q;
    logic          v_q;

    assign prod = er_s[k] * TK;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= ev_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q   <= ef_s[k][15] ? prod[60:30] : er_s[k];
        q_q   <= eq_s[k];
        z_q2  <= ez_s[k];
        tag_q <= et_s[k];
      end
    end

    if (k < 15) begin : g_f
      logic [15:0] f_q;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          f_q <= {ef_s[k][14:0], 1'b0};
        end
      end
      assign ef_s[k+1] = f_q;
    end

    assign er_s[k+1] = r_q;
    assign eq_s[k+1] = q_q;
    assign ez_s[k+1] = z_q2;
    assign et_s[k+1] = tag_q;
    assign ev_s[k+1] = v_q;
  end

  logic [4:0]     sh;
  logic [Q_W-1:0] res;
  assign sh  = eq_s[16][4:0] + 5'd14;
  assign res = (ez_s[16] || eq_s[16] > 7'd16) ? '0 : Q_W'(er_s[16] >> sh);

  logic           v_q;
  logic [Q_W-1:0] pw_q;
  logic [TW-1:0]  tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= ev_s[16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pw_q  <= res;
      tag_q <= et_s[16];
    end
  end

  assign valid_o = v_q;
  assign pw_o    = pw_q;
  assign tag_o   = tag_q;

endmodule

`default_nettype wire
